/* hdl/ax25_timer_recovery_defines.svh */
// assertion macros shared by the timer recovery rtl
// no dependencies; included by files that carry concurrent checks
`ifndef AX25_TIMER_RECOVERY_DEFINES_SVH
`define AX25_TIMER_RECOVERY_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define AX25TR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define AX25TR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ax25tr_pkg.sv */
// types and constants for the ax25 timer recovery pipeline
// no dependencies; imported by every module of the block
package ax25tr_pkg;

  typedef enum logic [2:0] {
    LS_DISC  = 3'd0,
    LS_SETUP = 3'd1,
    LS_DPEND = 3'd2,
    LS_CONN  = 3'd3,
    LS_RECOV = 3'd4
  } link_state_t;

  typedef enum logic [1:0] {
    FK_NONE = 2'd0,
    FK_CTRL = 2'd1,
    FK_RETX = 2'd2
  } frame_kind_t;

  typedef enum logic [1:0] {
    T3_LEAVE   = 2'd0,
    T3_RESTART = 2'd1,
    T3_STOP    = 2'd2
  } t3_act_t;

  localparam logic OP_T1 = 1'b0;
  localparam logic OP_T3 = 1'b1;

  localparam logic [1:0] CFG_RETRY_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_BACKOFF_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_POLL_THRESHOLD = 2'd2;
  localparam logic [1:0] CFG_OLD_PROTOCOL   = 2'd3;

  localparam logic [7:0] CTL_DM_PF   = 8'h1F;
  localparam logic [7:0] CTL_SABM_PF = 8'h3F;
  localparam logic [7:0] CTL_DISC_PF = 8'h53;
  localparam logic [7:0] CTL_RR_PF   = 8'h11;
  localparam logic [7:0] CTL_RNR_PF  = 8'h15;

  localparam logic [7:0] RETRY_MAX         = 8'hFF;
  localparam logic [7:0] PEER_DOWN_RETRIES = 8'd2;
  localparam logic [2:0] WIN_MIN           = 3'd1;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  link_state;
    logic [7:0]  retry_count;
    logic [31:0] t1_period;
    logic [2:0]  window_size;
    logic [2:0]  unacked_count;
    logic [2:0]  send_seq;
    logic [2:0]  recv_seq;
    logic [16:0] queue_head;
    logic        peer_down;
    logic        dama_holding;
    logic        local_busy;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  retry_limit;
    logic [7:0]  backoff_limit;
    logic [15:0] poll_threshold;
    logic        old_protocol;
  } cfg_t;

  // stage one result: operands with the arithmetic already done
  typedef struct packed {
    logic        opcode;
    logic [2:0]  link_state;
    logic [7:0]  retry_count;
    logic [7:0]  retry_inc;
    logic [31:0] t1_period;
    logic [34:0] t1_scaled;
    logic [2:0]  window_size;
    logic        unacked_nz;
    logic [2:0]  ns;
    logic [2:0]  recv_seq;
    logic        poll_retx;
    logic        peer_down;
    logic        dama_holding;
    logic        local_busy;
    logic        over;
    logic        below_backoff;
    logic        peer_retries_out;
    logic        old_protocol;
  } prep_t;

  typedef struct packed {
    logic [2:0]  new_link_state;
    logic [7:0]  new_retry_count;
    logic [31:0] new_t1_period;
    logic [2:0]  new_window_size;
    frame_kind_t frame_kind;
    logic        is_response;
    logic [7:0]  control_byte;
    logic        flush_queue;
    logic        timed_out;
    logic        dama_retransmit;
    logic        t1_restart;
    t3_act_t     t3_action;
  } result_t;

  // handshake enables for the three pipeline registers
  typedef struct packed {
    logic load_s1;
    logic load_s2;
    logic load_s3;
  } pipe_ctl_t;

endpackage

/* hdl/ax25tr_prep.sv */
// stage one: retry increment, t1 scaling and limit compares
// depends on ax25tr_pkg
module ax25tr_prep
  import ax25tr_pkg::*;
(
  input  logic     clk,
  input  logic     load,
  input  in_item_t item,
  input  cfg_t     cfg,
  output prep_t    prep_r
);

  prep_t      prep_nxt;
  logic [7:0] rinc;
  logic [16:0] qh_len;

  always_comb begin
    rinc   = (item.retry_count == RETRY_MAX) ? RETRY_MAX : item.retry_count + 8'd1;
    qh_len = item.queue_head - 17'd1;

    prep_nxt.opcode           = item.opcode;
    prep_nxt.link_state       = item.link_state;
    prep_nxt.retry_count      = item.retry_count;
    prep_nxt.retry_inc        = rinc;
    prep_nxt.t1_period        = item.t1_period;
    // t1 * 5 + 2, the divide by four is taken in stage two
    prep_nxt.t1_scaled        = {1'b0, item.t1_period, 2'b00} + {3'b000, item.t1_period}
                                + 35'd2;
    prep_nxt.window_size      = item.window_size;
    prep_nxt.unacked_nz       = (item.unacked_count != 3'd0);
    prep_nxt.ns               = item.send_seq - item.unacked_count;
    prep_nxt.recv_seq         = item.recv_seq;
    prep_nxt.poll_retx        = (item.queue_head != 17'd0) &&
                                ((qh_len < {1'b0, cfg.poll_threshold}) || cfg.old_protocol);
    prep_nxt.peer_down        = item.peer_down;
    prep_nxt.dama_holding     = item.dama_holding;
    prep_nxt.local_busy       = item.local_busy;
    prep_nxt.over             = (cfg.retry_limit != 8'd0) && (rinc > cfg.retry_limit);
    prep_nxt.below_backoff    = (rinc < cfg.backoff_limit);
    prep_nxt.peer_retries_out = (rinc > PEER_DOWN_RETRIES);
    prep_nxt.old_protocol     = cfg.old_protocol;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prep_r <= prep_nxt;
    end
  end

endmodule

/* hdl/ax25tr_decide.sv */
// stage two: state decision, frame choice and timer actions
// depends on ax25tr_pkg
module ax25tr_decide
  import ax25tr_pkg::*;
(
  input  logic    clk,
  input  logic    load,
  input  prep_t   prep,
  output result_t res_r
);

  result_t     res_nxt;
  logic [32:0] t1_div;
  logic [31:0] t1_sat;
  frame_kind_t poll_kind;
  logic [7:0]  poll_ctl;

  always_comb begin
    t1_div = prep.t1_scaled[34:2];
    t1_sat = t1_div[32] ? 32'hFFFF_FFFF : t1_div[31:0];

    // poll: oldest i-frame again, or rr/rnr command with poll bit
    poll_kind = prep.poll_retx ? FK_RETX : FK_CTRL;
    if (prep.poll_retx) begin
      poll_ctl = {prep.recv_seq, 1'b1, prep.ns, 1'b0};
    end else begin
      poll_ctl = prep.local_busy ? CTL_RNR_PF : CTL_RR_PF;
    end

    res_nxt.new_link_state  = prep.link_state;
    res_nxt.new_retry_count = prep.retry_count;
    res_nxt.new_t1_period   = prep.t1_period;
    res_nxt.new_window_size = prep.window_size;
    res_nxt.frame_kind      = FK_NONE;
    res_nxt.is_response     = 1'b0;
    res_nxt.control_byte    = 8'h00;
    res_nxt.flush_queue     = 1'b0;
    res_nxt.timed_out       = 1'b0;
    res_nxt.dama_retransmit = 1'b0;
    res_nxt.t1_restart      = 1'b0;
    res_nxt.t3_action       = T3_LEAVE;

    if (prep.opcode == OP_T1) begin
      if (prep.dama_holding) begin
        if (prep.unacked_nz) begin
          res_nxt.new_retry_count = prep.retry_inc;
          if (prep.over) begin
            res_nxt.frame_kind     = FK_CTRL;
            res_nxt.is_response    = 1'b1;
            res_nxt.control_byte   = CTL_DM_PF;
            res_nxt.flush_queue    = 1'b1;
            res_nxt.timed_out      = 1'b1;
            res_nxt.new_link_state = LS_DISC;
          end else begin
            res_nxt.dama_retransmit = 1'b1;
            res_nxt.t1_restart      = 1'b1;
          end
        end else begin
          res_nxt.t1_restart = 1'b1;
        end
      end else begin
        res_nxt.new_retry_count = prep.retry_inc;
        if (prep.below_backoff) begin
          res_nxt.new_t1_period = t1_sat;
        end
        if (prep.window_size > WIN_MIN) begin
          res_nxt.new_window_size = prep.window_size - 3'd1;
        end
        case (prep.link_state)
          LS_SETUP: begin
            if (prep.peer_down) begin
              if (prep.peer_retries_out) begin
                res_nxt.flush_queue    = 1'b1;
                res_nxt.timed_out      = 1'b1;
                res_nxt.new_link_state = LS_DISC;
              end else begin
                res_nxt.t1_restart = 1'b1;
              end
            end else if (prep.over) begin
              res_nxt.flush_queue    = 1'b1;
              res_nxt.timed_out      = 1'b1;
              res_nxt.new_link_state = LS_DISC;
            end else begin
              res_nxt.frame_kind   = FK_CTRL;
              res_nxt.control_byte = CTL_SABM_PF;
              res_nxt.t1_restart   = 1'b1;
            end
          end
          LS_DPEND: begin
            if (prep.over) begin
              res_nxt.timed_out      = 1'b1;
              res_nxt.new_link_state = LS_DISC;
            end else begin
              res_nxt.frame_kind   = FK_CTRL;
              res_nxt.control_byte = CTL_DISC_PF;
              res_nxt.t1_restart   = 1'b1;
            end
          end
          LS_CONN, LS_RECOV: begin
            if (prep.over) begin
              res_nxt.frame_kind     = FK_CTRL;
              res_nxt.is_response    = 1'b1;
              res_nxt.control_byte   = CTL_DM_PF;
              res_nxt.flush_queue    = 1'b1;
              res_nxt.timed_out      = 1'b1;
              res_nxt.new_link_state = LS_DISC;
            end else begin
              res_nxt.frame_kind     = poll_kind;
              res_nxt.control_byte   = poll_ctl;
              res_nxt.t1_restart     = 1'b1;
              res_nxt.t3_action      = T3_STOP;
              res_nxt.new_link_state = LS_RECOV;
            end
          end
          default: begin
            // disconnected and unused codes: counters move, nothing sent
          end
        endcase
      end
    end else if (!prep.old_protocol) begin
      if (prep.dama_holding) begin
        res_nxt.t3_action = T3_RESTART;
      end else if (prep.link_state == LS_CONN) begin
        res_nxt.new_retry_count = 8'd0;
        res_nxt.frame_kind      = poll_kind;
        res_nxt.control_byte    = poll_ctl;
        res_nxt.t1_restart      = 1'b1;
        res_nxt.t3_action       = T3_STOP;
        res_nxt.new_link_state  = LS_RECOV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* hdl/ax25_timer_recovery.sv */
// top level of the ax25 t1/t3 timer recovery decision pipeline
// depends on ax25tr_pkg, ax25tr_prep, ax25tr_decide and the assertion macros
`include "ax25_timer_recovery_defines.svh"

// usage
//   in_*  : one timer expiry per transaction, opcode in tuser, link snapshot in tdata
//   out_* : one decision per expiry, frame kind in tuser, the rest in tdata
//   cfg_* : register writes (retry limit, backoff limit, poll threshold,
//           old protocol), taken on any cycle with cfg_wr_en high; write only
//           while the pipeline is empty
// timing
//   three register stages: arithmetic, decision, output register
//   out_tvalid rises once the input transaction has passed the arithmetic,
//   decision and output registers
//   throughput one transaction per cycle while out_tready is high, set by
//   the per-stage handshake; each stage refills as soon as the stage after
//   it moves, so a new transaction is taken while a result waits at the output
// reset
//   rst_n low clears all valid bits and loads the register defaults
//   (retry limit 10, backoff limit 5, poll threshold 128, version 2)
// stall
//   with out_tready low the output holds; upstream stages fill up and
//   in_tready drops once all three are occupied, nothing is lost or repeated
module ax25_timer_recovery
  import ax25tr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  // link_state[2:0] retry_count[10:3] t1_period[42:11] window_size[45:43]
  // unacked_count[48:46] send_seq[51:49] recv_seq[54:52] queue_head[71:55]
  // peer_down[72] dama_holding[73] local_busy[74], zero fill above
  input  logic [79:0] in_tdata,
  // opcode[0]
  input  logic [0:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  // new_link_state[2:0] new_retry_count[10:3] new_t1_period[42:11]
  // new_window_size[45:43] is_response[46] control_byte[54:47] flush_queue[55]
  // timed_out[56] dama_retransmit[57] t1_restart[58] t3_action[60:59], zero fill
  output logic [63:0] out_tdata,
  // frame_kind[1:0]
  output logic [1:0]  out_tuser,
  // configuration port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t      cfg_r;
  in_item_t  item;
  prep_t     prep;
  result_t   res;
  result_t   out_r;
  pipe_ctl_t ctl;
  logic      v1_r;
  logic      v2_r;
  logic      v3_r;
  logic      lat_probe;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_limit    <= 8'd10;
      cfg_r.backoff_limit  <= 8'd5;
      cfg_r.poll_threshold <= 16'd128;
      cfg_r.old_protocol   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RETRY_LIMIT:    cfg_r.retry_limit    <= cfg_data[7:0];
        CFG_BACKOFF_LIMIT:  cfg_r.backoff_limit  <= cfg_data[7:0];
        CFG_POLL_THRESHOLD: cfg_r.poll_threshold <= cfg_data;
        CFG_OLD_PROTOCOL:   cfg_r.old_protocol   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // unpack the input transaction
  always_comb begin
    item.opcode        = in_tuser[0];
    item.link_state    = in_tdata[2:0];
    item.retry_count   = in_tdata[10:3];
    item.t1_period     = in_tdata[42:11];
    item.window_size   = in_tdata[45:43];
    item.unacked_count = in_tdata[48:46];
    item.send_seq      = in_tdata[51:49];
    item.recv_seq      = in_tdata[54:52];
    item.queue_head    = in_tdata[71:55];
    item.peer_down     = in_tdata[72];
    item.dama_holding  = in_tdata[73];
    item.local_busy    = in_tdata[74];
  end

  // each stage loads when it is empty or the stage after it moves on
  always_comb begin
    ctl.load_s3 = !v3_r || out_tready;
    ctl.load_s2 = !v2_r || ctl.load_s3;
    ctl.load_s1 = !v1_r || ctl.load_s2;
  end

  assign in_tready = ctl.load_s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ctl.load_s1) v1_r <= in_tvalid;
      if (ctl.load_s2) v2_r <= v1_r;
      if (ctl.load_s3) v3_r <= v2_r;
    end
  end

  ax25tr_prep u_prep (
    .clk    (clk),
    .load   (ctl.load_s1),
    .item   (item),
    .cfg    (cfg_r),
    .prep_r (prep)
  );

  ax25tr_decide u_decide (
    .clk   (clk),
    .load  (ctl.load_s2),
    .prep  (prep),
    .res_r (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (ctl.load_s3) begin
      out_r <= res;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tuser  = out_r.frame_kind;
  assign out_tdata  = {3'b000, out_r.t3_action, out_r.t1_restart, out_r.dama_retransmit,
                       out_r.timed_out, out_r.flush_queue, out_r.control_byte,
                       out_r.is_response, out_r.new_window_size, out_r.new_t1_period,
                       out_r.new_retry_count, out_r.new_link_state};

  // a transaction entering an empty pipeline
  assign lat_probe = in_tvalid && in_tready && !v1_r && !v2_r && !v3_r;

  `AX25TR_ASSERT_IMP(a_full_when_blocked, clk, rst_n, !in_tready, v1_r && v2_r && v3_r,
    "input blocked while a stage is free")
  `AX25TR_ASSERT_NXT(a_s1_held, clk, rst_n, v1_r && !ctl.load_s2, v1_r,
    "stage one dropped a stalled transaction")
  `AX25TR_ASSERT_IMP(a_latency, clk, rst_n,
    $past(lat_probe, 3) && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3),
    out_tvalid, "result missing three cycles after entry")
  `AX25TR_ASSERT_IMP(a_no_frame_clean, clk, rst_n,
    out_tvalid && (out_tuser == FK_NONE),
    (out_r.control_byte == 8'h00) && !out_r.is_response,
    "control byte set with no frame")
  `AX25TR_ASSERT_IMP(a_drop_state, clk, rst_n, out_tvalid && out_r.timed_out,
    (out_r.new_link_state == LS_DISC) && !out_r.t1_restart,
    "timeout without disconnect")

endmodule

/* bench/tb_ax25_timer_recovery.sv */
// self-checking bench for the ax25 t1/t3 timer recovery decision block
// needs only ax25tr_pkg and the ax25_timer_recovery rtl; expected decisions come
// from a behavioural predictor kept inside this module
module tb_ax25_timer_recovery
  import ax25tr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // generous ceiling on the number of cycles in a run
  localparam int unsigned CYCLE_LIMIT = 200_000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // link_state, retry_count, t1_period, window_size, unacked_count, send_seq,
  // recv_seq, queue_head, peer_down, dama_holding, local_busy (lowest bit up)
  logic [79:0] in_tdata   = '0;
  // opcode
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // new_link_state, new_retry_count, new_t1_period, new_window_size, is_response,
  // control_byte, flush_queue, timed_out, dama_retransmit, t1_restart, t3_action
  logic [63:0] out_tdata;
  // frame_kind
  logic [1:0]  out_tuser;
  logic        cfg_wr_en  = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  // bench copy of the registers, reset values of the block
  logic [7:0]  cfg_retry_limit    = 8'd10;
  logic [7:0]  cfg_backoff_limit  = 8'd5;
  logic [15:0] cfg_poll_threshold = 16'd128;
  logic        cfg_old_protocol   = 1'b0;

  // idling switches for the sender and the receiver
  bit src_gaps    = 1'b1;
  bit sink_stalls = 1'b1;

  result_t         expected_decisions[$];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count    = 0;

  ax25_timer_recovery u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[ax25_timer_recovery] ERROR");
      $finish;
    end
  end

  // receiver back-pressure, roughly 15 stalled cycles in a hundred
  always @(posedge clk) begin
    out_tready <= !(sink_stalls && ($urandom_range(0, 99) < 15));
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // poll: resend the oldest i-frame if it is short enough (or always on
  // version 1), otherwise an rr/rnr command with the poll bit
  function automatic result_t with_poll(input in_item_t x, input result_t r);
    logic [2:0] ns;
    if (x.queue_head != 17'd0 &&
        ((x.queue_head - 17'd1) < {1'b0, cfg_poll_threshold} || cfg_old_protocol)) begin
      ns             = x.send_seq - x.unacked_count;
      r.frame_kind   = FK_RETX;
      r.control_byte = {x.recv_seq, 1'b1, ns, 1'b0};
    end else begin
      r.frame_kind   = FK_CTRL;
      r.control_byte = x.local_busy ? CTL_RNR_PF : CTL_RR_PF;
    end
    r.is_response = 1'b0;
    r.t1_restart  = 1'b1;
    r.t3_action   = T3_STOP;
    return r;
  endfunction

  // works out the decision for one timer expiry under the current registers
  function automatic result_t decide_expiry(input in_item_t x);
    result_t     r;
    logic [7:0]  retries;
    logic [34:0] scaled;
    logic        over;
    r                 = '0;
    r.frame_kind      = FK_NONE;
    r.t3_action       = T3_LEAVE;
    r.new_link_state  = x.link_state;
    r.new_retry_count = x.retry_count;
    r.new_t1_period   = x.t1_period;
    r.new_window_size = x.window_size;
    retries           = x.retry_count;

    if (x.opcode == OP_T1) begin
      if (x.dama_holding) begin
        // master holds the channel: only count a retry if frames are out
        if (x.unacked_count != 3'd0) begin
          if (retries != RETRY_MAX) retries = retries + 8'd1;
          r.new_retry_count = retries;
          if (cfg_retry_limit != 8'd0 && retries > cfg_retry_limit) begin
            r.frame_kind     = FK_CTRL;
            r.is_response    = 1'b1;
            r.control_byte   = CTL_DM_PF;
            r.flush_queue    = 1'b1;
            r.timed_out      = 1'b1;
            r.new_link_state = LS_DISC;
            return r;
          end
          r.dama_retransmit = 1'b1;
        end
        r.t1_restart = 1'b1;
        return r;
      end

      if (retries != RETRY_MAX) retries = retries + 8'd1;
      r.new_retry_count = retries;
      // back off by 5/4 with rounding, clipped at the top
      if (retries < cfg_backoff_limit) begin
        scaled          = ({3'd0, x.t1_period} * 35'd5 + 35'd2) >> 2;
        r.new_t1_period = (scaled[34:32] != 3'd0) ? 32'hFFFF_FFFF : scaled[31:0];
      end
      if (x.window_size > WIN_MIN) r.new_window_size = x.window_size - 3'd1;
      over = (cfg_retry_limit != 8'd0) && (retries > cfg_retry_limit);

      case (x.link_state)
        LS_SETUP: begin
          if (x.peer_down) begin
            if (retries > PEER_DOWN_RETRIES) begin
              r.flush_queue    = 1'b1;
              r.timed_out      = 1'b1;
              r.new_link_state = LS_DISC;
            end else begin
              r.t1_restart = 1'b1;
            end
          end else if (over) begin
            r.flush_queue    = 1'b1;
            r.timed_out      = 1'b1;
            r.new_link_state = LS_DISC;
          end else begin
            r.frame_kind   = FK_CTRL;
            r.control_byte = CTL_SABM_PF;
            r.t1_restart   = 1'b1;
          end
        end
        LS_DPEND: begin
          if (over) begin
            r.timed_out      = 1'b1;
            r.new_link_state = LS_DISC;
          end else begin
            r.frame_kind   = FK_CTRL;
            r.control_byte = CTL_DISC_PF;
            r.t1_restart   = 1'b1;
          end
        end
        LS_CONN, LS_RECOV: begin
          if (over) begin
            r.frame_kind     = FK_CTRL;
            r.is_response    = 1'b1;
            r.control_byte   = CTL_DM_PF;
            r.flush_queue    = 1'b1;
            r.timed_out      = 1'b1;
            r.new_link_state = LS_DISC;
          end else begin
            r                = with_poll(x, r);
            r.new_link_state = LS_RECOV;
          end
        end
        default: ;
      endcase
    end else if (!cfg_old_protocol) begin
      // t3: version 1 ignores it entirely
      if (x.dama_holding) begin
        r.t3_action = T3_RESTART;
      end else if (x.link_state == LS_CONN) begin
        r.new_retry_count = 8'd0;
        r                 = with_poll(x, r);
        r.new_link_state  = LS_RECOV;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
  endtask

  // outputs are sampled on the falling edge, the transaction completes at
  // the next rising edge since tvalid and tready only move on rising edges
  always @(negedge clk) begin : check_decisions
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.new_link_state  = out_tdata[2:0];
      got.new_retry_count = out_tdata[10:3];
      got.new_t1_period   = out_tdata[42:11];
      got.new_window_size = out_tdata[45:43];
      got.is_response     = out_tdata[46];
      got.control_byte    = out_tdata[54:47];
      got.flush_queue     = out_tdata[55];
      got.timed_out       = out_tdata[56];
      got.dama_retransmit = out_tdata[57];
      got.t1_restart      = out_tdata[58];
      got.t3_action       = t3_act_t'(out_tdata[60:59]);
      got.frame_kind      = frame_kind_t'(out_tuser);
      if (expected_decisions.size() == 0) begin
        report_mismatch("result with nothing outstanding", out_tdata[31:0], '0);
      end else begin
        want = expected_decisions.pop_front();
        if (got.new_link_state !== want.new_link_state)
          report_mismatch("new_link_state", 32'(got.new_link_state),
                          32'(want.new_link_state));
        if (got.new_retry_count !== want.new_retry_count)
          report_mismatch("new_retry_count", 32'(got.new_retry_count),
                          32'(want.new_retry_count));
        if (got.new_t1_period !== want.new_t1_period)
          report_mismatch("new_t1_period", got.new_t1_period, want.new_t1_period);
        if (got.new_window_size !== want.new_window_size)
          report_mismatch("new_window_size", 32'(got.new_window_size),
                          32'(want.new_window_size));
        if (got.frame_kind !== want.frame_kind)
          report_mismatch("frame_kind", 32'(got.frame_kind), 32'(want.frame_kind));
        if (got.is_response !== want.is_response)
          report_mismatch("is_response", 32'(got.is_response), 32'(want.is_response));
        if (got.control_byte !== want.control_byte)
          report_mismatch("control_byte", 32'(got.control_byte), 32'(want.control_byte));
        if (got.flush_queue !== want.flush_queue)
          report_mismatch("flush_queue", 32'(got.flush_queue), 32'(want.flush_queue));
        if (got.timed_out !== want.timed_out)
          report_mismatch("timed_out", 32'(got.timed_out), 32'(want.timed_out));
        if (got.dama_retransmit !== want.dama_retransmit)
          report_mismatch("dama_retransmit", 32'(got.dama_retransmit),
                          32'(want.dama_retransmit));
        if (got.t1_restart !== want.t1_restart)
          report_mismatch("t1_restart", 32'(got.t1_restart), 32'(want.t1_restart));
        if (got.t3_action !== want.t3_action)
          report_mismatch("t3_action", 32'(got.t3_action), 32'(want.t3_action));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // random link snapshot, biased towards the interesting corners of the
  // current register settings
  function automatic in_item_t rand_expiry();
    in_item_t    x;
    int unsigned pick;
    int          near;
    x.opcode = ($urandom_range(0, 9) < 6) ? OP_T1 : OP_T3;

    pick = $urandom_range(0, 19);
    if (pick < 2)       x.link_state = 3'($urandom_range(5, 7));
    else if (pick < 8)  x.link_state = LS_CONN;
    else if (pick < 12) x.link_state = LS_RECOV;
    else if (pick < 15) x.link_state = LS_SETUP;
    else if (pick < 17) x.link_state = LS_DPEND;
    else                x.link_state = LS_DISC;

    case ($urandom_range(0, 3))
      0: x.retry_count = 8'($urandom_range(0, 3));
      1: begin
        near = int'(cfg_retry_limit) + int'($urandom_range(0, 2)) - 1;
        if (near < 0) near = 0;
        if (near > 255) near = 255;
        x.retry_count = 8'(near);
      end
      2: x.retry_count = 8'($urandom_range(250, 255));
      default: x.retry_count = 8'($urandom_range(0, 255));
    endcase

    case ($urandom_range(0, 3))
      0: x.t1_period = $urandom_range(32'hCCCC_CCC0, 32'hFFFF_FFFF);
      1: x.t1_period = $urandom_range(0, 20000);
      default: x.t1_period = $urandom;
    endcase

    x.window_size   = 3'($urandom_range(0, 7));
    x.unacked_count = 3'($urandom_range(0, 7));
    x.send_seq      = 3'($urandom_range(0, 7));
    x.recv_seq      = 3'($urandom_range(0, 7));

    case ($urandom_range(0, 4))
      0: x.queue_head = 17'd0;
      1: begin
        // straddle the poll threshold, queue_head is length plus one
        near = int'(cfg_poll_threshold) + int'($urandom_range(0, 2));
        if (near > 65536) near = 65536;
        x.queue_head = 17'(near);
      end
      2: x.queue_head = 17'($urandom_range(65535, 65536));
      default: x.queue_head = 17'($urandom_range(0, 65536));
    endcase

    x.dama_holding = ($urandom_range(0, 3) == 0);
    x.peer_down    = 1'($urandom_range(0, 1));
    x.local_busy   = 1'($urandom_range(0, 1));
    return x;
  endfunction

  // directed starting point: random content, chosen event, state and retries
  function automatic in_item_t base_expiry(input logic op, input logic [2:0] st,
                                           input logic [7:0] retries);
    in_item_t x;
    x              = rand_expiry();
    x.opcode       = op;
    x.link_state   = st;
    x.retry_count  = retries;
    x.dama_holding = 1'b0;
    x.peer_down    = 1'b0;
    return x;
  endfunction

  // offers one expiry, holds it until the transaction completes, then books
  // the predicted decision
  task automatic send_expiry(input in_item_t item);
    while (src_gaps && ($urandom_range(0, 99) < 15)) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= item.opcode;
    in_tdata  <= {5'd0, item.local_busy, item.dama_holding, item.peer_down,
                  item.queue_head, item.recv_seq, item.send_seq, item.unacked_count,
                  item.window_size, item.t1_period, item.retry_count, item.link_state};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    expected_decisions.push_back(decide_expiry(item));
  endtask

  // drop tvalid and let every outstanding decision come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_decisions.size() != 0) @(posedge clk);
  endtask

  // writes all four registers, one per cycle, only with the pipeline empty
  task automatic program_regs(input logic [7:0] retry_lim, input logic [7:0] backoff_lim,
                              input logic [15:0] poll_thr, input logic old_proto);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_RETRY_LIMIT;
    cfg_data  <= {8'd0, retry_lim};
    @(posedge clk);
    cfg_index <= CFG_BACKOFF_LIMIT;
    cfg_data  <= {8'd0, backoff_lim};
    @(posedge clk);
    cfg_index <= CFG_POLL_THRESHOLD;
    cfg_data  <= poll_thr;
    @(posedge clk);
    cfg_index <= CFG_OLD_PROTOCOL;
    cfg_data  <= {15'd0, old_proto};
    @(posedge clk);
    cfg_wr_en          <= 1'b0;
    cfg_retry_limit    = retry_lim;
    cfg_backoff_limit  = backoff_lim;
    cfg_poll_threshold = poll_thr;
    cfg_old_protocol   = old_proto;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // t1 in every state code, with window and period corners
  task automatic test_t1_states();
    in_item_t x;
    for (int st = 0; st < 8; st++) begin
      x = base_expiry(OP_T1, 3'(st), 8'd2);
      if (st == 0) x.window_size = 3'd0;
      if (st == 1) x.window_size = 3'd1;
      if (st == 3) begin
        x.window_size = 3'd7;
        x.t1_period   = 32'hFFFF_FFFF;   // backoff clips at the top
      end
      if (st == 4) x.t1_period = 32'd0;
      send_expiry(x);
    end
    wait_drained();
  endtask

  // retry limit reached in each state, retry saturation, setup with the peer down
  task automatic test_t1_limits();
    in_item_t x;
    send_expiry(base_expiry(OP_T1, LS_CONN, 8'd10));
    send_expiry(base_expiry(OP_T1, LS_RECOV, 8'd255));
    send_expiry(base_expiry(OP_T1, LS_DPEND, 8'd10));
    send_expiry(base_expiry(OP_T1, LS_SETUP, 8'd10));
    x = base_expiry(OP_T1, LS_SETUP, 8'd1);
    x.peer_down = 1'b1;
    send_expiry(x);
    x = base_expiry(OP_T1, LS_SETUP, 8'd2);
    x.peer_down = 1'b1;
    send_expiry(x);
    wait_drained();
  endtask

  // dama master holding: no frames out, frames out, frames out past the limit, t3
  task automatic test_dama_hold();
    in_item_t x;
    x = base_expiry(OP_T1, LS_CONN, 8'd200);
    x.dama_holding  = 1'b1;
    x.unacked_count = 3'd0;
    send_expiry(x);
    x = base_expiry(OP_T1, LS_RECOV, 8'd3);
    x.dama_holding  = 1'b1;
    x.unacked_count = 3'd5;
    send_expiry(x);
    x = base_expiry(OP_T1, LS_CONN, 8'd10);
    x.dama_holding  = 1'b1;
    x.unacked_count = 3'd7;
    send_expiry(x);
    x = base_expiry(OP_T3, LS_CONN, 8'd4);
    x.dama_holding = 1'b1;
    send_expiry(x);
    wait_drained();
  endtask

  // t3 polls around the threshold, rnr when busy, t3 outside connected state
  task automatic test_t3_polls();
    in_item_t x;
    x = base_expiry(OP_T3, LS_CONN, 8'd7);
    x.queue_head = 17'd0;
    x.local_busy = 1'b1;
    send_expiry(x);
    x = base_expiry(OP_T3, LS_CONN, 8'd0);
    x.queue_head    = 17'd1;
    x.send_seq      = 3'd0;
    x.unacked_count = 3'd7;
    x.recv_seq      = 3'd7;
    send_expiry(x);
    x = base_expiry(OP_T3, LS_CONN, 8'd255);
    x.queue_head = 17'd129;   // length equals threshold, so poll instead
    x.local_busy = 1'b0;
    send_expiry(x);
    x = base_expiry(OP_T3, LS_CONN, 8'd1);
    x.queue_head = 17'd65536;
    send_expiry(x);
    send_expiry(base_expiry(OP_T3, LS_DISC, 8'd3));
    send_expiry(base_expiry(OP_T3, 3'd7, 8'd3));
    wait_drained();
  endtask

  // register extremes: unlimited retries, version 1, zero threshold and backoff
  task automatic test_config_extremes();
    in_item_t x;
    program_regs(8'd0, 8'd255, 16'hFFFF, 1'b1);
    send_expiry(base_expiry(OP_T3, LS_CONN, 8'd9));
    x = base_expiry(OP_T1, LS_CONN, 8'd254);
    x.queue_head = 17'd65536;   // version 1 resends whatever the length
    send_expiry(x);
    wait_drained();
    program_regs(8'd255, 8'd0, 16'd0, 1'b0);
    send_expiry(base_expiry(OP_T1, LS_RECOV, 8'd255));
    x = base_expiry(OP_T3, LS_CONN, 8'd5);
    x.queue_head = 17'd1;
    send_expiry(x);
    wait_drained();
  endtask

  // random traffic over several register settings; the third phase runs
  // without gaps or stalls
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: program_regs(8'd10, 8'd5, 16'd128, 1'b0);
        1: program_regs(8'd0, 8'd255, 16'hFFFF, 1'b0);
        2: program_regs(8'd255, 8'd0, 16'd0, 1'b1);
        3: program_regs(8'd1, 8'd1, 16'd1, 1'b0);
        default: program_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      endcase
      src_gaps    = (phase != 2);
      sink_stalls = (phase != 2);
      repeat (150) send_expiry(rand_expiry());
      wait_drained();
    end
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_t1_states();
    test_t1_limits();
    test_dama_hold();
    test_t3_polls();
    test_config_extremes();
    test_random_traffic();

    // tail: nothing should trickle out after the last decision
    repeat (8) @(posedge clk);
    if (expected_decisions.size() != 0)
      report_mismatch("decisions never delivered", expected_decisions.size(), '0);
    if (mismatch_count == 0) begin
      $display("[ax25_timer_recovery] OK");
    end else begin
      $display("[ax25_timer_recovery] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ax25tr_pkg.sv
hdl/ax25tr_prep.sv
hdl/ax25tr_decide.sv
hdl/ax25_timer_recovery.sv
bench/tb_ax25_timer_recovery.sv
